// ===== rtl/lfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants, codes and types of the lowest free slot ID allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfsa_pkg;

  localparam int SLOT_COUNT_DEF   = 4096;
  localparam int GROUP_SIZE_DEF   = 512;
  localparam int HANDLE_WIDTH_DEF = 32;
  localparam int OCC_WORD_MAX     = 64;

  localparam int OPCODE_W = 2;
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int RES_ID_W = 12;

  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOLOCK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CLEAR,
    S_FREE_WR,
    S_LOOK_RD,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lfsa_ram.sv =====
// ----------------------------------------------------------------------------
// lfsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lowest_free_slot_id_allocator.sv =====
// ----------------------------------------------------------------------------
// Allocate scans occupancy words upward from word 0, and on reaching an absent group
// clears that group's words and takes its first slot. Free and lookup read one
// occupancy word; errors reply from decode. A reply waits while the output holds an
// untaken result. One request at a time: in_ready is high only in the idle state.
// Reset clears the group present bits and the control state; a group's occupancy
// words are cleared when allocate first reaches it, so no clearing pass runs.
// ----------------------------------------------------------------------------
// lowest_free_slot_id_allocator
// Slot table mapping small IDs to handles with lowest-free allocation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_slot_id_allocator #(
  parameter int SLOT_COUNT   = lfsa_pkg::SLOT_COUNT_DEF,
  parameter int GROUP_SIZE   = lfsa_pkg::GROUP_SIZE_DEF,
  parameter int HANDLE_WIDTH = lfsa_pkg::HANDLE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lfsa_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [lfsa_pkg::ID_W-1:0]     in_slot_id,
  input  wire logic [lfsa_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic                          in_handle_valid,
  input  wire logic                          in_lock_held,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lfsa_pkg::STATUS_W-1:0]      out_status,
  output logic [lfsa_pkg::RES_ID_W-1:0]      out_result_id,
  output logic [lfsa_pkg::HANDLE_W-1:0]      out_result_handle
);

  localparam int SW   = (HANDLE_WIDTH < lfsa_pkg::HANDLE_W) ? HANDLE_WIDTH
                                                            : lfsa_pkg::HANDLE_W;
  localparam int OW   = (GROUP_SIZE < lfsa_pkg::OCC_WORD_MAX) ? GROUP_SIZE
                                                              : lfsa_pkg::OCC_WORD_MAX;
  localparam int OBW  = $clog2(OW);
  localparam int WPG  = GROUP_SIZE / OW;
  localparam int WPGB = $clog2(WPG);
  localparam int NW   = (SLOT_COUNT + OW - 1) / OW;
  localparam int WIW  = $clog2(NW);
  localparam int SLW  = WIW + OBW;
  localparam int SIW  = $clog2(SLOT_COUNT);
  localparam int GC   = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GIW  = (GC > 1) ? $clog2(GC) : 1;
  localparam int GSB  = $clog2(GROUP_SIZE);
  localparam int CW   = (WPG > 1) ? WPGB : 1;
  localparam int IDW  = lfsa_pkg::ID_W;

  lfsa_pkg::state_t state_r, state_nxt;

  logic [lfsa_pkg::OPCODE_W-1:0] op_r;
  logic [IDW-1:0]                id_r;
  logic [SW-1:0]                 hdl_r;
  logic                          hv_r;
  logic                          lk_r;

  logic [WIW:0]    issue_w_r, issue_w_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [WIW-1:0]  chk_w_r, chk_w_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [GC-1:0]   present_r, present_nxt;

  logic [lfsa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [lfsa_pkg::RES_ID_W-1:0] res_id_r, res_id_nxt;
  logic [SW-1:0]                 res_hdl_r, res_hdl_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [lfsa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [lfsa_pkg::RES_ID_W-1:0] out_id_r, out_id_nxt;
  logic [SW-1:0]                 out_hdl_r, out_hdl_nxt;

  logic           occ_we;
  logic [WIW-1:0] occ_waddr;
  logic [OW-1:0]  occ_wdata;
  logic [WIW-1:0] occ_raddr;
  logic [OW-1:0]  occ_rdata;

  logic           hd_we;
  logic [SIW-1:0] hd_waddr;
  logic [SW-1:0]  hd_wdata;
  logic [SW-1:0]  hd_rdata;

  logic           found;
  logic [OBW-1:0] fbit;
  logic [SLW:0]   scan_sn;

  logic           in_range;
  logic [GIW-1:0] id_grp;
  logic [WIW-1:0] id_word;
  logic [OBW-1:0] id_bit;
  logic           at_end;
  logic           grp_start;
  logic [GIW-1:0] issue_grp;
  logic [WIW:0]   clr_w;

  lfsa_ram #(
    .WIDTH (OW),
    .DEPTH (NW)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  lfsa_ram #(
    .WIDTH (SW),
    .DEPTH (SLOT_COUNT)
  ) u_handle_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (id_r[SIW-1:0]),
    .rdata (hd_rdata)
  );

  assign in_ready          = (state_r == lfsa_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_handle = lfsa_pkg::HANDLE_W'(out_hdl_r);

  assign in_range  = ({1'b0, id_r} < (IDW + 1)'(SLOT_COUNT));
  assign id_grp    = GIW'(id_r >> GSB);
  assign id_word   = WIW'(id_r >> OBW);
  assign id_bit    = id_r[OBW-1:0];
  assign at_end    = (issue_w_r == (WIW + 1)'(NW));
  assign grp_start = ((issue_w_r & (WIW + 1)'(WPG - 1)) == '0);
  assign issue_grp = GIW'(issue_w_r >> WPGB);
  assign clr_w     = issue_w_r + (WIW + 1)'(cnt_r);

  always_comb begin
    found   = 1'b0;
    fbit    = '0;
    scan_sn = '0;
    for (int b = OW - 1; b >= 0; b--) begin
      scan_sn = {1'b0, chk_w_r, OBW'(b)};
      if (!occ_rdata[b] && (scan_sn < (SLW + 1)'(SLOT_COUNT))) begin
        found = 1'b1;
        fbit  = OBW'(b);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    issue_w_nxt    = issue_w_r;
    chk_v_nxt      = chk_v_r;
    chk_w_nxt      = chk_w_r;
    cnt_nxt        = cnt_r;
    present_nxt    = present_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_hdl_nxt    = res_hdl_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_hdl_nxt    = out_hdl_r;
    occ_we         = 1'b0;
    occ_waddr      = '0;
    occ_wdata      = '0;
    occ_raddr      = '0;
    hd_we          = 1'b0;
    hd_waddr       = '0;
    hd_wdata       = hdl_r;

    unique case (state_r)
      lfsa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lfsa_pkg::S_DECODE;
        end
      end

      lfsa_pkg::S_DECODE: begin
        res_id_nxt  = '0;
        res_hdl_nxt = '0;
        state_nxt   = lfsa_pkg::S_REPLY;
        priority case (op_r)
          lfsa_pkg::OP_ALLOC: begin
            if (hdl_r == '0) begin
              res_status_nxt = lfsa_pkg::ST_NULL;
            end else begin
              issue_w_nxt = '0;
              chk_v_nxt   = 1'b0;
              state_nxt   = lfsa_pkg::S_SCAN;
            end
          end
          lfsa_pkg::OP_FREE: begin
            priority if (hdl_r == '0) begin
              res_status_nxt = lfsa_pkg::ST_NULL;
            end else if (!hv_r || !in_range) begin
              res_status_nxt = lfsa_pkg::ST_INVALID;
            end else if (!lk_r) begin
              res_status_nxt = lfsa_pkg::ST_NOLOCK;
            end else if (!present_r[id_grp]) begin
              res_status_nxt = lfsa_pkg::ST_ABSENT;
            end else begin
              occ_raddr = id_word;
              state_nxt = lfsa_pkg::S_FREE_WR;
            end
          end
          lfsa_pkg::OP_LOOKUP: begin
            priority if (!in_range) begin
              res_status_nxt = lfsa_pkg::ST_INVALID;
            end else if (!present_r[id_grp]) begin
              res_status_nxt = lfsa_pkg::ST_ABSENT;
            end else begin
              occ_raddr = id_word;
              state_nxt = lfsa_pkg::S_LOOK_RD;
            end
          end
          default: begin
            res_status_nxt = lfsa_pkg::ST_INVALID;
          end
        endcase
      end

      lfsa_pkg::S_SCAN: begin
        priority if (chk_v_r && found) begin
          occ_we         = 1'b1;
          occ_waddr      = chk_w_r;
          occ_wdata      = occ_rdata | (OW'(1) << fbit);
          hd_we          = 1'b1;
          hd_waddr       = SIW'({chk_w_r, fbit});
          res_status_nxt = lfsa_pkg::ST_OK;
          res_id_nxt     = lfsa_pkg::RES_ID_W'({chk_w_r, fbit});
          state_nxt      = lfsa_pkg::S_REPLY;
        end else if (at_end) begin
          res_status_nxt = lfsa_pkg::ST_FULL;
          state_nxt      = lfsa_pkg::S_REPLY;
        end else if (grp_start && !present_r[issue_grp]) begin
          present_nxt[issue_grp] = 1'b1;
          cnt_nxt                = '0;
          chk_v_nxt              = 1'b0;
          state_nxt              = lfsa_pkg::S_CLEAR;
        end else begin
          occ_raddr   = issue_w_r[WIW-1:0];
          chk_w_nxt   = issue_w_r[WIW-1:0];
          chk_v_nxt   = 1'b1;
          issue_w_nxt = issue_w_r + (WIW + 1)'(1);
        end
      end

      lfsa_pkg::S_CLEAR: begin
        occ_we    = (clr_w < (WIW + 1)'(NW));
        occ_waddr = clr_w[WIW-1:0];
        occ_wdata = (cnt_r == '0) ? OW'(1) : '0;
        if (cnt_r == '0) begin
          hd_we    = 1'b1;
          hd_waddr = SIW'({issue_w_r[WIW-1:0], {OBW{1'b0}}});
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(WPG - 1)) begin
          res_status_nxt = lfsa_pkg::ST_OK;
          res_id_nxt     = lfsa_pkg::RES_ID_W'({issue_w_r[WIW-1:0], {OBW{1'b0}}});
          state_nxt      = lfsa_pkg::S_REPLY;
        end
      end

      lfsa_pkg::S_FREE_WR: begin
        occ_we         = 1'b1;
        occ_waddr      = id_word;
        occ_wdata      = occ_rdata & ~(OW'(1) << id_bit);
        res_status_nxt = lfsa_pkg::ST_OK;
        state_nxt      = lfsa_pkg::S_REPLY;
      end

      lfsa_pkg::S_LOOK_RD: begin
        res_status_nxt = lfsa_pkg::ST_OK;
        res_hdl_nxt    = occ_rdata[id_bit] ? hd_rdata : '0;
        state_nxt      = lfsa_pkg::S_REPLY;
      end

      lfsa_pkg::S_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_hdl_nxt    = res_hdl_r;
          state_nxt      = lfsa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lfsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfsa_pkg::S_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_opcode;
      id_r  <= in_slot_id;
      hdl_r <= in_handle[SW-1:0];
      hv_r  <= in_handle_valid;
      lk_r  <= in_lock_held;
    end
    issue_w_r    <= issue_w_nxt;
    chk_w_r      <= chk_w_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_hdl_r    <= res_hdl_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_hdl_r    <= out_hdl_nxt;
  end

endmodule

`default_nettype wire
